// File: hw/rtl/rqs_pkg.sv
// Shared types and constants for the record quicksort block.
`default_nettype none
package rqs_pkg;
   localparam int unsigned KEY_W = 32;
   localparam int unsigned PAY_W = 32;
   localparam logic [KEY_W-1:0] SIGN_BIAS = 32'h8000_0000;

   typedef enum logic [4:0] {
      ST_LOAD, ST_START, ST_POP, ST_POP_RD, ST_PIV_RD0, ST_PIV_W0, ST_PIV_SCAN, ST_PIV_WAIT,
      ST_LSCAN, ST_LWAIT, ST_RSCAN, ST_RWAIT, ST_SWAP_RD, ST_SWAP_W1, ST_SWAP_W2,
      ST_PUSH1, ST_PUSH2, ST_EMIT_RD, ST_EMIT_W, ST_EMIT_OUT
   } state_type;

   typedef struct packed {
      logic lt;
      logic eq;
   } cmp_type;
endpackage
`default_nettype wire

// File: hw/rtl/rqs_cmp.sv
// Shared key comparator, registered result.
`default_nettype none
module rqs_cmp (
   input  wire logic                       clock,
   input  wire logic [rqs_pkg::KEY_W-1:0]  a,
   input  wire logic [rqs_pkg::KEY_W-1:0]  b,
   output rqs_pkg::cmp_type               res
);
   rqs_pkg::cmp_type res_ff;
   always_ff @(posedge clock) begin
      res_ff.lt <= (a < b);
      res_ff.eq <= (a == b);
   end
   assign res = res_ff;
endmodule
`default_nettype wire

// File: hw/rtl/record_quicksort_top.sv
// Top level of the record quicksort block: record store, range stack and sequencer.
// Operation: loading stores each accepted item; after the last item the sort runs
// on one shared comparator and a single read address into the record store, a
// swap taking a read state and two write states, then emission reads, registers
// and offers each item in turn, holding while rsp_tready is low.
// Throughput: one set at a time; req_tready is low from the last item until emission ends.
// Reset: synchronous, active high; clears count, stack pointer, sequencer and output valid, not memories.
`default_nettype none
module record_quicksort_top #(
   parameter int unsigned MAX_RECORDS = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [63:0] req_tdata,   // rec_key[31:0], rec_payload[63:32]
   input  wire logic        req_tlast,   // is_last
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [63:0] rsp_tdata,   // out_key[31:0], out_payload[63:32]
   output      logic        rsp_tlast    // out_last
);
   localparam int unsigned AW = $clog2(MAX_RECORDS);
   localparam int unsigned CW = $clog2(MAX_RECORDS + 1);
   localparam int unsigned IW = AW + 2;
   localparam int unsigned KW = rqs_pkg::KEY_W;

   logic [KW-1:0] key_mem [MAX_RECORDS];
   logic [rqs_pkg::PAY_W-1:0] pay_mem [MAX_RECORDS];
   logic [2*AW-1:0] stk_mem [MAX_RECORDS];

   rqs_pkg::state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] sp_ff, sp_in;
   logic signed [IW-1:0] lo_ff, lo_in, hi_ff, hi_in, l_ff, l_in, r_ff, r_in, k_ff, k_in;
   logic [KW-1:0] piv_ff, piv_in, first_ff, first_in, ka_ff, ka_in;
   logic [rqs_pkg::PAY_W-1:0] pa_ff, pa_in;
   logic [KW-1:0] rdk_ff;
   logic [rqs_pkg::PAY_W-1:0] rdp_ff;
   logic [2*AW-1:0] rds_ff;
   logic [63:0] out_data_ff, out_data_in;
   logic out_last_ff, out_last_in, out_valid_ff, out_valid_in;

   logic [AW-1:0] raddr, waddr, saddr_r, saddr_w;
   logic kwe, swe;
   logic [KW-1:0] wkey;
   logic [rqs_pkg::PAY_W-1:0] wpay;
   logic [2*AW-1:0] wstk;
   logic [KW-1:0] ca, cb;
   rqs_pkg::cmp_type cmp;

   rqs_cmp u_cmp (.clock(clock), .a(ca), .b(cb), .res(cmp));

   always_ff @(posedge clock) begin
      if (kwe) begin
         key_mem[waddr] <= wkey;
         pay_mem[waddr] <= wpay;
      end
      rdk_ff <= key_mem[raddr];
      rdp_ff <= pay_mem[raddr];
      if (swe) stk_mem[saddr_w] <= wstk;
      rds_ff <= stk_mem[saddr_r];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rqs_pkg::ST_LOAD;
         count_ff <= '0;
         sp_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         sp_ff <= sp_in;
         out_valid_ff <= out_valid_in;
      end
      lo_ff <= lo_in; hi_ff <= hi_in; l_ff <= l_in; r_ff <= r_in; k_ff <= k_in;
      piv_ff <= piv_in; first_ff <= first_in; ka_ff <= ka_in; pa_ff <= pa_in;
      out_data_ff <= out_data_in; out_last_ff <= out_last_in;
   end

   assign req_tready = (state_ff == rqs_pkg::ST_LOAD);
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = out_data_ff;
   assign rsp_tlast = out_last_ff;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      sp_in = sp_ff;
      lo_in = lo_ff; hi_in = hi_ff; l_in = l_ff; r_in = r_ff; k_in = k_ff;
      piv_in = piv_ff; first_in = first_ff; ka_in = ka_ff; pa_in = pa_ff;
      out_data_in = out_data_ff; out_last_in = out_last_ff;
      out_valid_in = out_valid_ff;
      raddr = '0; waddr = count_ff[AW-1:0]; kwe = 1'b0;
      wkey = req_tdata[31:0] ^ rqs_pkg::SIGN_BIAS; wpay = req_tdata[63:32];
      saddr_r = '0; saddr_w = '0; swe = 1'b0; wstk = '0;
      ca = rdk_ff; cb = piv_ff;
      unique case (state_ff)
         rqs_pkg::ST_LOAD: begin
            if (req_tvalid) begin
               if (count_ff < CW'(MAX_RECORDS)) begin
                  kwe = 1'b1;
                  count_in = count_ff + 1'b1;
               end
               if (req_tlast) state_in = rqs_pkg::ST_START;
            end
         end
         rqs_pkg::ST_START: begin
            sp_in = '0;
            if (count_ff > CW'(1)) begin
               swe = 1'b1; saddr_w = '0;
               wstk = {AW'(count_ff - 1'b1), AW'(0)};
               sp_in = CW'(1);
               state_in = rqs_pkg::ST_POP;
            end else begin
               k_in = '0;
               state_in = (count_ff == '0) ? rqs_pkg::ST_LOAD : rqs_pkg::ST_EMIT_RD;
            end
         end
         rqs_pkg::ST_POP: begin
            if (sp_ff == '0) begin
               k_in = '0;
               state_in = rqs_pkg::ST_EMIT_RD;
            end else begin
               sp_in = sp_ff - 1'b1;
               saddr_r = AW'(sp_ff - 1'b1);
               state_in = rqs_pkg::ST_POP_RD;
            end
         end
         rqs_pkg::ST_POP_RD: begin
            lo_in = IW'(rds_ff[AW-1:0]);
            hi_in = IW'(rds_ff[2*AW-1:AW]);
            raddr = rds_ff[AW-1:0];
            state_in = rqs_pkg::ST_PIV_RD0;
         end
         rqs_pkg::ST_PIV_RD0: begin
            first_in = rdk_ff;
            k_in = lo_ff + 1'b1;
            raddr = AW'(lo_ff + 1'b1);
            state_in = rqs_pkg::ST_PIV_W0;
         end
         rqs_pkg::ST_PIV_W0: begin
            ca = rdk_ff; cb = first_ff;
            ka_in = rdk_ff;
            state_in = rqs_pkg::ST_PIV_SCAN;
         end
         rqs_pkg::ST_PIV_SCAN: begin
            if (!cmp.eq) begin
               piv_in = (first_ff < ka_ff) ? ka_ff : first_ff;
               l_in = lo_ff; r_in = hi_ff;
               raddr = AW'(lo_ff);
               state_in = rqs_pkg::ST_LWAIT;
            end else if (k_ff >= hi_ff) begin
               state_in = rqs_pkg::ST_POP;
            end else begin
               k_in = k_ff + 1'b1;
               raddr = AW'(k_ff + 1'b1);
               state_in = rqs_pkg::ST_PIV_W0;
            end
         end
         rqs_pkg::ST_LWAIT: begin
            ka_in = rdk_ff; pa_in = rdp_ff;
            state_in = rqs_pkg::ST_LSCAN;
         end
         rqs_pkg::ST_LSCAN: begin
            if (l_ff <= hi_ff && cmp.lt) begin
               l_in = l_ff + 1'b1;
               raddr = AW'(l_ff + 1'b1);
               state_in = rqs_pkg::ST_LWAIT;
            end else begin
               raddr = AW'(r_ff);
               state_in = rqs_pkg::ST_RWAIT;
            end
         end
         rqs_pkg::ST_RWAIT: begin
            state_in = rqs_pkg::ST_RSCAN;
         end
         rqs_pkg::ST_RSCAN: begin
            if (r_ff >= lo_ff && !cmp.lt) begin
               r_in = r_ff - 1'b1;
               raddr = AW'(r_ff - 1'b1);
               state_in = rqs_pkg::ST_RWAIT;
            end else if (l_ff < r_ff) begin
               raddr = AW'(r_ff);
               state_in = rqs_pkg::ST_SWAP_RD;
            end else begin
               state_in = rqs_pkg::ST_PUSH1;
            end
         end
         rqs_pkg::ST_SWAP_RD: begin
            raddr = AW'(r_ff);
            state_in = rqs_pkg::ST_SWAP_W1;
         end
         rqs_pkg::ST_SWAP_W1: begin
            kwe = 1'b1; waddr = AW'(l_ff); wkey = rdk_ff; wpay = rdp_ff;
            state_in = rqs_pkg::ST_SWAP_W2;
         end
         rqs_pkg::ST_SWAP_W2: begin
            kwe = 1'b1; waddr = AW'(r_ff); wkey = ka_ff; wpay = pa_ff;
            if (l_ff + 1'b1 <= r_ff - 1'b1) begin
               l_in = l_ff + 1'b1; r_in = r_ff - 1'b1;
               raddr = AW'(l_ff + 1'b1);
               state_in = rqs_pkg::ST_LWAIT;
            end else begin
               l_in = l_ff + 1'b1;
               state_in = rqs_pkg::ST_PUSH1;
            end
         end
         rqs_pkg::ST_PUSH1: begin
            if (l_ff <= lo_ff || l_ff > hi_ff) begin
               state_in = rqs_pkg::ST_POP;
            end else begin
               if (l_ff < hi_ff) begin
                  swe = 1'b1; saddr_w = AW'(sp_ff);
                  wstk = {AW'(hi_ff), AW'(l_ff)};
                  sp_in = sp_ff + 1'b1;
               end
               state_in = rqs_pkg::ST_PUSH2;
            end
         end
         rqs_pkg::ST_PUSH2: begin
            if (lo_ff < l_ff - 1'b1) begin
               swe = 1'b1; saddr_w = AW'(sp_ff);
               wstk = {AW'(l_ff - 1'b1), AW'(lo_ff)};
               sp_in = sp_ff + 1'b1;
            end
            state_in = rqs_pkg::ST_POP;
         end
         rqs_pkg::ST_EMIT_RD: begin
            raddr = AW'(k_ff);
            state_in = rqs_pkg::ST_EMIT_W;
         end
         rqs_pkg::ST_EMIT_W: begin
            if (!out_valid_ff || rsp_tready) begin
               out_data_in = {rdp_ff, rdk_ff ^ rqs_pkg::SIGN_BIAS};
               out_last_in = (k_ff + 1'b1 == IW'(count_ff));
               out_valid_in = 1'b1;
               state_in = rqs_pkg::ST_EMIT_OUT;
            end else begin
               raddr = AW'(k_ff);
            end
         end
         rqs_pkg::ST_EMIT_OUT: begin
            if (rsp_tready) begin
               out_valid_in = 1'b0;
               if (out_last_ff) begin
                  count_in = '0; sp_in = '0;
                  state_in = rqs_pkg::ST_LOAD;
               end else begin
                  k_in = k_ff + 1'b1;
                  state_in = rqs_pkg::ST_EMIT_RD;
               end
            end
         end
         default: state_in = rqs_pkg::ST_LOAD;
      endcase
      if (state_ff == rqs_pkg::ST_LSCAN || state_ff == rqs_pkg::ST_LWAIT) begin
         ca = (state_ff == rqs_pkg::ST_LWAIT) ? rdk_ff : ka_ff;
      end
   end

`ifndef SYNTHESIS
   a_ready_load: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid) else $error("ready while emitting");
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_RECORDS)) else $error("count overflow");
   a_sp_max: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= CW'(MAX_RECORDS)) else $error("stack overflow");
`endif
endmodule
`default_nettype wire

// File: bench/tb_top.sv
// Testbench for record_quicksort_top: directed sets plus random sets checked against a sorting predictor.
`default_nettype none
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_RECORDS = 64;
   localparam int WATCHDOG_LIMIT = 200000;

   typedef struct packed {
      logic [31:0] key;
      logic [31:0] payload;
      logic        last;
   } record_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic        rsp_tlast;

   record_quicksort_top #(.MAX_RECORDS(MAX_RECORDS)) i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
   );

   always #5 clock = ~clock;

   // biased keys compare unsigned like signed keys
   logic [31:0] sort_keys [MAX_RECORDS];
   logic [31:0] sort_pays [MAX_RECORDS];
   int          set_count = 0;
   record_type  sorted_q [$];
   record_type  stim_q [$];
   int          errors = 0;
   int          watchdog = 0;

   function automatic void swap_records(int x, int y);
      logic [31:0] t;
      t = sort_keys[x]; sort_keys[x] = sort_keys[y]; sort_keys[y] = t;
      t = sort_pays[x]; sort_pays[x] = sort_pays[y]; sort_pays[y] = t;
   endfunction

   function automatic void sort_and_queue();
      int          span_lo [$];
      int          span_hi [$];
      int          lo, hi, k, l, r;
      logic [31:0] piv;
      record_type  rec;
      if (set_count > 0) begin
         span_lo.push_back(0);
         span_hi.push_back(set_count - 1);
      end
      while (span_lo.size() > 0) begin
         lo = span_lo.pop_back();
         hi = span_hi.pop_back();
         k = lo + 1;
         while (k <= hi && sort_keys[k] == sort_keys[lo]) k++;
         if (k > hi) continue;
         piv = (sort_keys[lo] < sort_keys[k]) ? sort_keys[k] : sort_keys[lo];
         l = lo;
         r = hi;
         while (l <= r) begin
            while (l <= hi && sort_keys[l] < piv) l++;
            while (r >= lo && sort_keys[r] >= piv) r--;
            if (l < r) swap_records(l, r);
         end
         if (l <= lo || l > hi) continue;
         if (l < hi) begin
            span_lo.push_back(l);
            span_hi.push_back(hi);
         end
         if (lo < l - 1) begin
            span_lo.push_back(lo);
            span_hi.push_back(l - 1);
         end
      end
      for (int i = 0; i < set_count; i++) begin
         rec.key = sort_keys[i] ^ 32'h8000_0000;
         rec.payload = sort_pays[i];
         rec.last = (i == set_count - 1);
         sorted_q.push_back(rec);
      end
      set_count = 0;
   endfunction

   function automatic void predict_record(record_type rec);
      if (set_count < MAX_RECORDS) begin
         sort_keys[set_count] = rec.key ^ 32'h8000_0000;
         sort_pays[set_count] = rec.payload;
         set_count++;
      end
      if (rec.last) sort_and_queue();
   endfunction

   function automatic logic [31:0] rand_key(int mode);
      case (mode)
         0: return $urandom_range(0, 3);
         1: return 32'h8000_0000 + $urandom_range(0, 2);
         2: return 32'h7FFF_FFFF - $urandom_range(0, 2);
         default: return $urandom();
      endcase
   endfunction

   function automatic void add_set(int n, int mode, bit tail_last);
      record_type rec;
      for (int i = 0; i < n; i++) begin
         rec.key = (mode == 4) ? 32'h1234_5678 : rand_key(mode == 5 ? $urandom_range(0, 3) : mode);
         rec.payload = $urandom();
         rec.last = tail_last && (i == n - 1);
         stim_q.push_back(rec);
      end
   endfunction

   // directed sets, expected outputs typed in for the simple ones
   record_type dir_in [10];
   record_type dir_out [10];
   initial begin
      dir_in[0] = '{32'h0000_0005, 32'hFFFF_FFFF, 1'b1};
      dir_out[0] = '{32'h0000_0005, 32'hFFFF_FFFF, 1'b1};
      dir_in[1] = '{32'h7FFF_FFFF, 32'h0000_0001, 1'b0};
      dir_in[2] = '{32'h8000_0000, 32'h0000_0002, 1'b0};
      dir_in[3] = '{32'h0000_0000, 32'h0000_0000, 1'b1};
      dir_out[1] = '{32'h8000_0000, 32'h0000_0002, 1'b0};
      dir_out[2] = '{32'h0000_0000, 32'h0000_0000, 1'b0};
      dir_out[3] = '{32'h7FFF_FFFF, 32'h0000_0001, 1'b1};
      dir_in[4] = '{32'hFFFF_FFFF, 32'hAAAA_AAAA, 1'b0};
      dir_in[5] = '{32'hFFFF_FFFF, 32'h5555_5555, 1'b1};
      dir_out[4] = dir_in[4];
      dir_out[5] = dir_in[5];
      dir_in[6] = '{32'h0000_0001, 32'h0000_000A, 1'b0};
      dir_in[7] = '{32'h0000_0001, 32'h0000_000B, 1'b0};
      dir_in[8] = '{32'hFFFF_FFFF, 32'h0000_000C, 1'b0};
      dir_in[9] = '{32'h0000_0000, 32'h0000_000D, 1'b1};
   end

   int idle_left = 0;
   int stall_left = 0;
   bit calm = 1'b0;

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (sorted_q.size() == 0) begin
               $error("unexpected item key=%h", rsp_tdata[31:0]);
               errors++;
            end else begin
               record_type exp_rec;
               exp_rec = sorted_q.pop_front();
               if (rsp_tdata[31:0] !== exp_rec.key) begin
                  $error("out_key expected %h actual %h", exp_rec.key, rsp_tdata[31:0]);
                  errors++;
               end
               if (rsp_tdata[63:32] !== exp_rec.payload) begin
                  $error("out_payload expected %h actual %h", exp_rec.payload, rsp_tdata[63:32]);
                  errors++;
               end
               if (rsp_tlast !== exp_rec.last) begin
                  $error("out_last expected %b actual %b", exp_rec.last, rsp_tlast);
                  errors++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!calm && $urandom_range(0, 15) == 0) begin
            stall_left = $urandom_range(1, 13) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) watchdog = 0;
         else watchdog++;
         if (watchdog >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin
      record_type rec;
      int n;
      repeat (10) @(posedge clock);
      // directed sets first; the first three are checked against typed expectations, the fourth against the predictor
      for (int i = 0; i < 10; i++) stim_q.push_back(dir_in[i]);
      add_set(MAX_RECORDS + 3, 3, 1'b1);  // overflow, last still sorts
      add_set(MAX_RECORDS, 4, 1'b1);      // all equal keys
      for (int s = 0; s < 31; s++) begin
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, MAX_RECORDS + 2)
                                         : $urandom_range(1, 12);
         add_set(n, $urandom_range(0, 5), 1'b1);
      end
      reset <= 1'b0;
      for (int i = 0; i < 4; i++) sorted_q.push_back(dir_out[i]);
      for (int i = 4; i < 6; i++) sorted_q.push_back(dir_out[i]);
      for (int i = 6; i < 10; i++) predict_record(dir_in[i]);
      for (int i = 10; i < stim_q.size(); i++) predict_record(stim_q[i]);
      for (int i = 0; i < stim_q.size(); i++) begin
         rec = stim_q[i];
         if (i > stim_q.size() - 40) calm = 1'b1;
         if (!calm && $urandom_range(0, 7) == 0) begin
            idle_left = $urandom_range(1, 13);
            req_tvalid <= 1'b0;
            repeat (idle_left) @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata <= {rec.payload, rec.key};
         req_tlast <= rec.last;
         @(posedge clock);
         while (!req_tready) @(posedge clock);
      end
      req_tvalid <= 1'b0;
      while (sorted_q.size() > 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule
`default_nettype wire

// File: files.f
hw/rtl/rqs_pkg.sv
hw/rtl/rqs_cmp.sv
hw/rtl/record_quicksort_top.sv
bench/tb_top.sv
